### rtl/h264_rtp_nal_depacketizer_unit_macros.svh
// Assertion macros shared by the checker of the H.264 RTP depacketizer.
// Include this file by bare name; it holds macros only.
`ifndef H264_RTP_NAL_DEPACKETIZER_UNIT_MACROS_SVH
`define H264_RTP_NAL_DEPACKETIZER_UNIT_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define H264DP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs across reset.
`define H264DP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/h264dp_pkg.sv
// Types and constants of the H.264 RTP NAL depacketizer.
// Used by the parse core, the output stage and the top level.
package h264dp_pkg;

    localparam logic [6:0] EXP_TYPE_RESET = 7'd96;

    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1f;
    localparam logic [7:0] NAL_F_BIT      = 8'h80;
    localparam logic [7:0] FU_E_BIT       = 8'h40;
    localparam logic [7:0] FU_R_BIT       = 8'h20;
    localparam logic [7:0] NAL_NRI_MASK   = 8'he0;
    localparam logic [4:0] TYPE_SINGLE_MAX = 5'd23;
    localparam logic [4:0] TYPE_STAP_A    = 5'd24;
    localparam logic [4:0] TYPE_FU_A      = 5'd28;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_STAP_A = 2'd1;
    localparam logic [1:0] KIND_FU_A   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [1:0] PH_LEN_HIGH  = 2'd0;
    localparam logic [1:0] PH_LEN_LOW   = 2'd1;
    localparam logic [1:0] PH_UNIT_HEAD = 2'd2;
    localparam logic [1:0] PH_UNIT_DATA = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [6:0]  packet_type;
        logic [31:0] rtp_timestamp;
        logic        rtp_marker;
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic        first_of_packet;
        logic        last_of_packet;
    } item_t;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_byte_valid;
        logic        nal_first;
        logic        nal_last;
        logic        packet_end;
        logic [1:0]  status;
        logic        fragment_discarded;
        logic [31:0] out_timestamp;
        logic        out_marker;
    } result_t;

    function automatic logic [1:0] merge_err(input logic [1:0] cur, input logic [1:0] code);
        merge_err = (cur == ST_OK) ? code : cur;
    endfunction

    function automatic logic nal_header_ok(input logic [7:0] h);
        logic [4:0] t;
        t = h[4:0];
        nal_header_ok = ((h & NAL_F_BIT) == 8'h00) && (t >= 5'd1) && (t <= TYPE_SINGLE_MAX);
    endfunction

endpackage

### rtl/h264dp_core.sv
// Parse core: packet and fragment state registers plus the per-byte decode
// of single NAL, STAP-A and FU-A payloads. Depends on h264dp_pkg.
module h264dp_core
    import h264dp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  item_t      item,
    input  logic [6:0] exp_type,
    output logic       res_valid,
    output result_t    res
);

    logic        frag_active_reg, frag_active_next;
    logic [7:0]  frag_header_reg, frag_header_next;
    logic [31:0] frag_ts_reg, frag_ts_next;
    logic [15:0] byte_pos_reg, byte_pos_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] agg_rem_reg, agg_rem_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [1:0]  fu_flags_reg, fu_flags_next;
    logic [1:0]  err_reg, err_next;

    logic [7:0]  b;
    logic [4:0]  t;
    logic [7:0]  nalh;
    logic [15:0] len;
    logic        fu_s;
    logic        fu_e;

    always_comb begin
        frag_active_next = frag_active_reg;
        frag_header_next = frag_header_reg;
        frag_ts_next     = frag_ts_reg;
        byte_pos_next    = byte_pos_reg;
        kind_next        = kind_reg;
        first_byte_next  = first_byte_reg;
        phase_next       = phase_reg;
        agg_rem_next     = agg_rem_reg;
        len_high_next    = len_high_reg;
        fu_flags_next    = fu_flags_reg;
        err_next         = err_reg;
        res_valid        = 1'b0;
        res              = '0;
        b                = item.payload_byte;
        t                = item.payload_byte[4:0];
        nalh             = (first_byte_reg & NAL_NRI_MASK) | {3'b000, t};
        len              = {len_high_reg, item.payload_byte};
        fu_s             = 1'b0;
        fu_e             = 1'b0;

        if (accept && item.cmd) begin
            frag_active_next = 1'b0;
            frag_header_next = 8'h00;
            frag_ts_next     = 32'h0;
        end else if (accept) begin
            if (item.first_of_packet) begin
                byte_pos_next   = 16'h0;
                kind_next       = KIND_SINGLE;
                first_byte_next = 8'h00;
                phase_next      = PH_LEN_HIGH;
                agg_rem_next    = 16'h0;
                len_high_next   = 8'h00;
                fu_flags_next   = 2'b00;
                err_next        = ST_OK;
            end
            if (item.byte_present) begin
                if (byte_pos_next == 16'h0) begin
                    first_byte_next = b;
                    if (item.packet_type != exp_type || (b & NAL_F_BIT) != 8'h00) begin
                        err_next = merge_err(err_next, ST_INVALID);
                    end else if (t >= 5'd1 && t <= TYPE_SINGLE_MAX) begin
                        if (frag_active_reg) begin
                            err_next = merge_err(err_next, ST_INVALID);
                        end else begin
                            kind_next          = KIND_SINGLE;
                            res.nal_byte       = b;
                            res.nal_byte_valid = 1'b1;
                            res.nal_first      = 1'b1;
                            res.nal_last       = item.last_of_packet;
                        end
                    end else if (t == TYPE_STAP_A) begin
                        if (frag_active_reg) begin
                            err_next = merge_err(err_next, ST_INVALID);
                        end else begin
                            kind_next  = KIND_STAP_A;
                            phase_next = PH_LEN_HIGH;
                        end
                    end else if (t == TYPE_FU_A) begin
                        kind_next = KIND_FU_A;
                    end else begin
                        err_next = merge_err(err_next, ST_UNSUPPORTED);
                    end
                    if (err_next != ST_OK) begin
                        kind_next = KIND_REJECT;
                    end
                end else if (err_next == ST_OK) begin
                    case (kind_next)
                        KIND_SINGLE: begin
                            res.nal_byte       = b;
                            res.nal_byte_valid = 1'b1;
                            res.nal_last       = item.last_of_packet;
                        end
                        KIND_STAP_A: begin
                            if (phase_next == PH_LEN_HIGH) begin
                                len_high_next = b;
                                phase_next    = PH_LEN_LOW;
                            end else if (phase_next == PH_LEN_LOW) begin
                                if (len == 16'h0) begin
                                    err_next = merge_err(err_next, ST_INVALID);
                                end else begin
                                    agg_rem_next = len;
                                    phase_next   = PH_UNIT_HEAD;
                                end
                            end else if (phase_next == PH_UNIT_HEAD && !nal_header_ok(b)) begin
                                err_next = merge_err(err_next, ST_INVALID);
                            end else begin
                                res.nal_byte       = b;
                                res.nal_byte_valid = 1'b1;
                                res.nal_first      = (phase_next == PH_UNIT_HEAD);
                                agg_rem_next       = agg_rem_next - 16'd1;
                                if (agg_rem_next == 16'h0) begin
                                    res.nal_last = 1'b1;
                                    phase_next   = PH_LEN_HIGH;
                                end else begin
                                    phase_next = PH_UNIT_DATA;
                                end
                            end
                        end
                        KIND_FU_A: begin
                            if (byte_pos_next == 16'd1) begin
                                fu_flags_next   = {(b & FU_E_BIT) != 8'h00, b[7]};
                                first_byte_next = nalh;
                                if ((b & FU_R_BIT) != 8'h00 || (b[7] && (b & FU_E_BIT) != 8'h00)
                                        || t == 5'd0 || t > TYPE_SINGLE_MAX) begin
                                    err_next = merge_err(err_next, ST_INVALID);
                                end else if (b[7]) begin
                                    if (frag_active_reg) begin
                                        err_next = merge_err(err_next, ST_INVALID);
                                    end else begin
                                        res.nal_byte       = nalh;
                                        res.nal_byte_valid = 1'b1;
                                        res.nal_first      = 1'b1;
                                    end
                                end else if (frag_active_reg) begin
                                    if (item.rtp_timestamp != frag_ts_reg
                                            || nalh != frag_header_reg) begin
                                        err_next = merge_err(err_next, ST_INVALID);
                                    end
                                end
                            end else if (fu_flags_next[0] || frag_active_reg) begin
                                res.nal_byte       = b;
                                res.nal_byte_valid = 1'b1;
                                res.nal_last       = item.last_of_packet && fu_flags_next[1];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (byte_pos_next != 16'hffff) begin
                    byte_pos_next = byte_pos_next + 16'd1;
                end
            end

            if (item.last_of_packet) begin
                if (!item.byte_present) begin
                    err_next = merge_err(err_next, ST_INVALID);
                end
                fu_s = fu_flags_next[0];
                fu_e = fu_flags_next[1];
                if (err_next == ST_OK && kind_next == KIND_STAP_A) begin
                    if (byte_pos_next == 16'd1 || phase_next != PH_LEN_HIGH) begin
                        err_next = merge_err(err_next, ST_INVALID);
                    end
                end else if (err_next == ST_OK && kind_next == KIND_FU_A) begin
                    if (byte_pos_next < 16'd3) begin
                        err_next = merge_err(err_next, ST_INVALID);
                    end else if (fu_s) begin
                        frag_active_next = 1'b1;
                        frag_header_next = first_byte_next;
                        frag_ts_next     = item.rtp_timestamp;
                        if (item.rtp_marker && !fu_e) begin
                            err_next = merge_err(err_next, ST_INVALID);
                        end
                    end else if (!frag_active_reg) begin
                        res.fragment_discarded = 1'b1;
                    end else if (item.rtp_marker && !fu_e) begin
                        err_next = merge_err(err_next, ST_INVALID);
                    end else if (fu_e) begin
                        frag_active_next = 1'b0;
                        frag_header_next = 8'h00;
                        frag_ts_next     = 32'h0;
                    end
                end
                res.status      = err_next;
                byte_pos_next   = 16'h0;
                kind_next       = KIND_SINGLE;
                first_byte_next = 8'h00;
                phase_next      = PH_LEN_HIGH;
                agg_rem_next    = 16'h0;
                len_high_next   = 8'h00;
                fu_flags_next   = 2'b00;
                err_next        = ST_OK;
            end

            if (!res.nal_byte_valid) begin
                res.nal_byte  = 8'h00;
                res.nal_first = 1'b0;
                res.nal_last  = 1'b0;
            end
            res.packet_end    = item.last_of_packet;
            res.out_timestamp = item.rtp_timestamp;
            res.out_marker    = item.rtp_marker;
            res_valid         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frag_active_reg <= 1'b0;
            frag_header_reg <= 8'h00;
            frag_ts_reg     <= 32'h0;
            byte_pos_reg    <= 16'h0;
            kind_reg        <= KIND_SINGLE;
            first_byte_reg  <= 8'h00;
            phase_reg       <= PH_LEN_HIGH;
            agg_rem_reg     <= 16'h0;
            len_high_reg    <= 8'h00;
            fu_flags_reg    <= 2'b00;
            err_reg         <= ST_OK;
        end else begin
            frag_active_reg <= frag_active_next;
            frag_header_reg <= frag_header_next;
            frag_ts_reg     <= frag_ts_next;
            byte_pos_reg    <= byte_pos_next;
            kind_reg        <= kind_next;
            first_byte_reg  <= first_byte_next;
            phase_reg       <= phase_next;
            agg_rem_reg     <= agg_rem_next;
            len_high_reg    <= len_high_next;
            fu_flags_reg    <= fu_flags_next;
            err_reg         <= err_next;
        end
    end

endmodule

### rtl/h264dp_out_stage.sv
// Result register of the depacketizer: holds one result until the
// downstream side takes it. Depends on h264dp_pkg.
module h264dp_out_stage
    import h264dp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    input  logic    m_tready,
    output logic    m_tvalid,
    output result_t res_out,
    output logic    in_ready
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

endmodule

### rtl/h264_rtp_nal_depacketizer_unit.sv
// Top level of the H.264 RTP NAL depacketizer (single NAL, STAP-A, FU-A).
// Instantiates h264dp_core and h264dp_out_stage; depends on h264dp_pkg.
//
//  channel | ports                        | carries
//  --------+------------------------------+---------------------------------
//  input   | s_tvalid s_tready s_tdata .. | one payload byte or a command
//  result  | m_tvalid m_tready m_tdata .. | one NAL byte slot plus status
//  config  | cfg_we cfg_wdata             | expected RTP payload type
//
// One request per clock while not stalled: the decode of a byte sits between the state
// registers and the result register, so results appear in the cycle after accept.
// A discontinuity request updates fragment state and yields no result.
// Input is stalled only while the result register is full and not taken.
// Synchronous active-low reset clears all state but the result data register; payload type resets to 96.
module h264_rtp_nal_depacketizer_unit
    import h264dp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // packet_type[6:0], rtp_timestamp[38:7], rtp_marker[39],
    // payload_byte[47:40], first_of_packet[48], zero fill[55:49]
    input  logic [55:0] s_tdata,
    // cmd[0], byte_present[1]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // nal_byte[7:0], nal_byte_valid[8], nal_first[9], nal_last[10],
    // out_timestamp[42:11], out_marker[43], zero fill[47:44]
    output logic [47:0] m_tdata,
    // status[1:0], fragment_discarded[2]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [6:0] exp_type_reg;
    item_t      item;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    res_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_type_reg <= EXP_TYPE_RESET;
        end else if (cfg_we) begin
            exp_type_reg <= cfg_wdata;
        end
    end

    always_comb begin
        item.cmd             = s_tuser[0];
        item.packet_type     = s_tdata[6:0];
        item.rtp_timestamp   = s_tdata[38:7];
        item.rtp_marker      = s_tdata[39];
        item.payload_byte    = s_tdata[47:40];
        item.byte_present    = s_tuser[1];
        item.first_of_packet = s_tdata[48];
        item.last_of_packet  = s_tlast;
    end

    assign accept = s_tvalid && s_tready;

    h264dp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (item),
        .exp_type  (exp_type_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    h264dp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res_in   (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_out  (res_q),
        .in_ready (s_tready)
    );

    assign m_tdata = {4'b0000, res_q.out_marker, res_q.out_timestamp, res_q.nal_last,
                      res_q.nal_first, res_q.nal_byte_valid, res_q.nal_byte};
    assign m_tuser = {res_q.fragment_discarded, res_q.status};
    assign m_tlast = res_q.packet_end;

endmodule

### rtl/h264dp_checker.sv
// Port-level checker for the H.264 RTP depacketizer, bound to the top level.
// Depends on the assertion macros header.
`include "h264_rtp_nal_depacketizer_unit_macros.svh"

module h264dp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    `H264DP_ASSERT_RST(a_hold_result, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast), "result changed while stalled")

    `H264DP_ASSERT_RST(a_status_on_end, aclk, aresetn,
        m_tvalid && !m_tlast |-> m_tuser == 3'b000, "status or discard flag outside packet end")

    `H264DP_ASSERT_RST(a_stall_cause, aclk, aresetn,
        !s_tready |-> m_tvalid && !m_tready, "input stalled without a blocked result")

    `H264DP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind h264_rtp_nal_depacketizer_unit h264dp_checker u_chk (.*);
